// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
package bpa_pkg;
   localparam int LEVELS_DEF = 11;
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;
endpackage

// ===== rtl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// Buddy page allocator over a pool of 2^(LEVELS-1) pages.
// Command channel: req_func/req_pages/req_offset are taken when start is
// high and busy is low. Allocate rounds req_pages up to a power of two
// (zero counts as one) and splits larger blocks as needed; free finds the
// block that holds req_offset and merges it with free buddies upward.
// Result: one word per command on rsp_ok/rsp_block_offset/rsp_block_order,
// valid for a single cycle while done is high. The receiver cannot stall.
// Sequencing: a sequencer works on one command at a time. Each tree level
// visited takes a sequence of mark and link memory accesses, and those
// memories have synchronous reads. busy drops in the done cycle, so the
// next word can be taken then.
// Reset: after reset a clearing pass writes zero into all 2^LEVELS node
// marks, one entry a cycle, with busy held high. Bucket 0 then holds the
// whole pool and all other lists are empty.
module buddy_page_allocator #(
   parameter int LEVELS = bpa_pkg::LEVELS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_func,
   input  logic [11:0]              req_pages,
   input  logic [9:0]               req_offset,
   output logic                     done,
   output logic                     rsp_ok,
   output logic [9:0]               rsp_block_offset,
   output logic [3:0]               rsp_block_order
);
   localparam int PB = LEVELS - 1;          // page bits
   localparam int NB = LEVELS;              // node bits
   localparam int LB = PB + 1;              // link width, NIL = 2^PB
   localparam int BB = $clog2(LEVELS);      // bucket index bits
   localparam logic [LB-1:0] NIL = LB'(1) << PB;
   localparam logic [NB-1:0] NODES = {NB{1'b1}};

   typedef enum logic [16:0] {
      S_CLR   = 17'h00001, S_IDLE  = 17'h00002, S_AFIND = 17'h00004,
      S_SPL   = 17'h00008, S_SPLRM = 17'h00010, S_SPLPR = 17'h00020,
      S_SPLPL = 17'h00040, S_AGET  = 17'h00080, S_FRD   = 17'h00100,
      S_FCHK  = 17'h00200, S_FPUT  = 17'h00400, S_MRD   = 17'h00800,
      S_MCHK  = 17'h01000, S_RM    = 17'h02000, S_RMW   = 17'h04000,
      S_RMX   = 17'h08000, S_RESP  = 17'h10000
   } state_type;

   // list ops: each one a short micro-sequence
   typedef enum logic [1:0] {OP_PUT, OP_PUSH, OP_REM} lop_type;

   state_type state_ff, state_in;
   logic [LB-1:0] head_ff [LEVELS];
   logic [LB-1:0] tail_ff [LEVELS];
   logic [LB-1:0] head_in [LEVELS];
   logic [LB-1:0] tail_in [LEVELS];

   logic [NB-1:0] clr_ff, clr_in;
   logic [BB-1:0] tgt_ff, tgt_in, up_ff, up_in;
   logic [NB-1:0] cur_ff, cur_in;
   logic [PB-1:0] off_ff, off_in;
   logic          ok_ff, ok_in;
   logic [PB-1:0] rpage_ff, rpage_in;
   logic [3:0]    rord_ff, rord_in;
   logic [1:0]    sub_ff, sub_in;
   logic [1:0]    rmcnt_ff, rmcnt_in;
   logic [LB-1:0] pr_ff, pr_in, nx_ff, nx_in;
   logic          mbit_ff, mbit_in;
   logic          done_ff, done_in;
   logic [PB-1:0] rmpg_ff, rmpg_in;

   // mark memory
   logic          mk_we;
   logic [NB-1:0] mk_wa, mk_ra;
   logic          mk_wd, mk_rd;
   // link memories
   logic          ln_we, lp_we;
   logic [PB-1:0] ln_wa, lp_wa, ln_ra, lp_ra;
   logic [LB-1:0] ln_wd, lp_wd, ln_rd, lp_rd;

   bpa_ram #(.WIDTH(1), .DEPTH(2**NB)) u_marks (
      .clock(clock), .wr_en(mk_we), .wr_addr(mk_wa), .wr_data(mk_wd),
      .rd_addr(mk_ra), .rd_data(mk_rd));
   bpa_ram #(.WIDTH(LB), .DEPTH(2**PB)) u_next (
      .clock(clock), .wr_en(ln_we), .wr_addr(ln_wa), .wr_data(ln_wd),
      .rd_addr(ln_ra), .rd_data(ln_rd));
   bpa_ram #(.WIDTH(LB), .DEPTH(2**PB)) u_prev (
      .clock(clock), .wr_en(lp_we), .wr_addr(lp_wa), .wr_data(lp_wd),
      .rd_addr(lp_ra), .rd_data(lp_rd));

   function automatic logic [NB-1:0] node_of(logic [PB-1:0] p, logic [BB-1:0] b);
      logic [NB-1:0] base;
      base = (NB'(1) << b) - NB'(1);
      return base + NB'({1'b0, p} >> (PB - int'(b)));
   endfunction

   function automatic logic [PB-1:0] page_of(logic [NB-1:0] n, logic [BB-1:0] b);
      logic [NB-1:0] base;
      base = (NB'(1) << b) - NB'(1);
      return PB'((n - base) << (PB - int'(b)));
   endfunction

   // order of a page count: ceil(log2(max(n,1)))
   function automatic logic [4:0] order_of(logic [11:0] n);
      logic [4:0] o;
      o = 5'd0;
      for (int i = 0; i < 12; i++) begin
         if ((13'(1) << i) < 13'(n)) o = 5'(i + 1);
      end
      return o;
   endfunction

   // list op context
   lop_type       lop;
   logic [BB-1:0] lb;
   logic [PB-1:0] lpg;
   logic [PB-1:0] rp;
   logic [NB-1:0] bud;
   logic [NB-1:0] par;
   logic [4:0]    ord;
   logic          found;
   logic [BB-1:0] fidx;

   assign bud = cur_ff[0] ? cur_ff + NB'(1) : cur_ff - NB'(1);
   assign par = (cur_ff - NB'(1)) >> 1;
   assign ord = order_of(req_pages);

   always_comb begin
      found = 1'b0;
      fidx = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (BB'(i) < tgt_ff && head_ff[i] != NIL) begin
            found = 1'b1;
            fidx = BB'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      clr_in = clr_ff;
      tgt_in = tgt_ff;
      up_in = up_ff;
      cur_in = cur_ff;
      off_in = off_ff;
      ok_in = ok_ff;
      rpage_in = rpage_ff;
      rord_in = rord_ff;
      sub_in = sub_ff;
      rmcnt_in = rmcnt_ff;
      pr_in = pr_ff;
      nx_in = nx_ff;
      mbit_in = mbit_ff;
      rmpg_in = rmpg_ff;
      done_in = 1'b0;
      mk_we = 1'b0; mk_wa = cur_ff; mk_wd = 1'b0; mk_ra = cur_ff;
      ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = '0;
      lp_we = 1'b0; lp_wa = '0; lp_wd = '0; lp_ra = '0;
      lop = OP_PUT; lb = '0; lpg = '0;

      unique case (state_ff)
         S_CLR: begin
            mk_we = 1'b1; mk_wa = clr_ff; mk_wd = 1'b0;
            // page zero starts alone on bucket 0
            ln_we = 1'b1; ln_wd = NIL;
            lp_we = 1'b1; lp_wd = NIL;
            clr_in = clr_ff + NB'(1);
            if (clr_ff == NODES) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               off_in = PB'(req_offset);
               ok_in = 1'b1;
               sub_in = '0;
               if (req_func == bpa_pkg::FUNC_ALLOC) begin
                  if (ord > 5'(PB)) begin
                     ok_in = 1'b0; rpage_in = '0; rord_in = '0;
                     state_in = S_RESP;
                  end else begin
                     tgt_in = BB'(PB - int'(ord));
                     rord_in = 4'(ord);
                     state_in = S_AFIND;
                  end
               end else begin
                  up_in = BB'(PB);
                  cur_in = node_of(PB'(req_offset), BB'(PB));
                  state_in = S_FRD;
               end
            end
         end
         S_AFIND: begin
            if (head_ff[tgt_ff] != NIL) begin
               state_in = S_AGET;
            end else if (found) begin
               up_in = fidx;
               cur_in = node_of(PB'(head_ff[fidx]), fidx);
               state_in = S_SPL;
            end else begin
               ok_in = 1'b0; rpage_in = '0; rord_in = '0;
               state_in = S_RESP;
            end
         end
         S_SPL: begin
            // sub 0..2: mark cur, left, right
            mk_we = 1'b1;
            unique case (sub_ff)
               2'd0: begin mk_wa = cur_ff; mk_wd = 1'b1; end
               2'd1: begin mk_wa = (cur_ff << 1) + NB'(1); mk_wd = 1'b0; end
               default: begin mk_wa = (cur_ff << 1) + NB'(2); mk_wd = 1'b0; end
            endcase
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd2) begin
               sub_in = '0;
               state_in = (head_ff[up_ff] != NIL) ? S_SPLRM : S_SPLPR;
            end
         end
         S_SPLRM: begin
            lop = OP_REM; lb = up_ff; lpg = PB'(head_ff[up_ff]);
         end
         S_SPLPR: begin
            lop = OP_PUSH; lb = up_ff + BB'(1);
            lpg = page_of((cur_ff << 1) + NB'(2), up_ff + BB'(1));
         end
         S_SPLPL: begin
            lop = OP_PUSH; lb = up_ff + BB'(1);
            lpg = page_of((cur_ff << 1) + NB'(1), up_ff + BB'(1));
         end
         S_AGET: begin
            lop = OP_REM; lb = tgt_ff; lpg = PB'(head_ff[tgt_ff]);
         end
         S_FRD: begin
            mk_ra = cur_ff;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (up_ff != '0 && !mk_rd) begin
               up_in = up_ff - BB'(1);
               cur_in = node_of(off_ff, up_ff - BB'(1));
               state_in = S_FRD;
            end else begin
               rpage_in = page_of(cur_ff, up_ff);
               rord_in = 4'(PB - int'(up_ff));
               state_in = S_FPUT;
            end
         end
         S_FPUT: begin
            lop = OP_PUT; lb = up_ff; lpg = page_of(cur_ff, up_ff);
         end
         S_MRD: begin
            // sub 0 read cur, sub 1 read buddy
            if (sub_ff == 2'd0) begin
               mk_ra = cur_ff;
               sub_in = 2'd1;
            end else begin
               mk_ra = bud;
               mbit_in = mk_rd;
               sub_in = '0;
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (mbit_ff || mk_rd) begin
               state_in = S_RESP;
            end else begin
               rmcnt_in = '0;
               state_in = S_RM;
            end
         end
         S_RM: begin
            lop = OP_REM; lb = up_ff;
            lpg = (rmcnt_ff == 2'd0) ? page_of(cur_ff, up_ff) : page_of(bud, up_ff);
         end
         S_RMX: begin
            mk_we = 1'b1; mk_wa = par; mk_wd = 1'b0;
            cur_in = par;
            up_in = up_ff - BB'(1);
            state_in = S_RMW;
         end
         S_RMW: begin
            lop = OP_PUT; lb = up_ff; lpg = page_of(cur_ff, up_ff);
         end
         S_RESP: begin
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // page being removed, held once the head moves
      rp = (sub_ff == 2'd0) ? lpg : rmpg_ff;

      // list op micro-sequence, shared by list states
      if (state_ff == S_SPLRM || state_ff == S_SPLPR || state_ff == S_SPLPL ||
          state_ff == S_AGET || state_ff == S_FPUT || state_ff == S_RM ||
          state_ff == S_RMW) begin
         case (lop)
            OP_PUT: begin
               ln_we = 1'b1; ln_wa = lpg; ln_wd = NIL;
               lp_we = 1'b1; lp_wa = lpg; lp_wd = tail_ff[lb];
               if (tail_ff[lb] == NIL) begin
                  head_in[lb] = LB'(lpg);
               end else begin
                  ln_wa = PB'(tail_ff[lb]); ln_wd = LB'(lpg);
                  sub_in = 2'd1;
               end
               if (sub_ff == 2'd1) begin
                  ln_wa = lpg; ln_wd = NIL;
                  lp_we = 1'b0;
                  head_in = head_ff;
               end
               tail_in[lb] = LB'(lpg);
               if (sub_ff == 2'd1 || tail_ff[lb] == NIL) begin
                  sub_in = '0;
               end
            end
            OP_PUSH: begin
               lp_we = 1'b1; lp_wa = lpg; lp_wd = NIL;
               ln_we = 1'b1; ln_wa = lpg; ln_wd = head_ff[lb];
               if (head_ff[lb] == NIL) begin
                  tail_in[lb] = LB'(lpg);
               end else begin
                  lp_wa = PB'(head_ff[lb]); lp_wd = LB'(lpg);
                  sub_in = 2'd1;
               end
               if (sub_ff == 2'd1) begin
                  lp_wa = lpg; lp_wd = NIL;
                  ln_we = 1'b0;
                  tail_in = tail_ff;
               end
               head_in[lb] = LB'(lpg);
               if (sub_ff == 2'd1 || head_ff[lb] == NIL) begin
                  sub_in = '0;
               end
            end
            default: begin
               // remove: sub0 read links, sub1 latch, sub2 fix neighbors, sub3 clear own
               ln_ra = rp; lp_ra = rp;
               rmpg_in = rp;
               unique case (sub_ff)
                  2'd0: sub_in = 2'd1;
                  2'd1: begin
                     pr_in = lp_rd; nx_in = ln_rd;
                     sub_in = 2'd2;
                  end
                  2'd2: begin
                     if (pr_ff == NIL) begin
                        head_in[lb] = nx_ff;
                     end else begin
                        ln_we = 1'b1; ln_wa = PB'(pr_ff); ln_wd = nx_ff;
                     end
                     if (nx_ff == NIL) begin
                        tail_in[lb] = pr_ff;
                     end else begin
                        lp_we = 1'b1; lp_wa = PB'(nx_ff); lp_wd = pr_ff;
                     end
                     sub_in = 2'd3;
                  end
                  default: begin
                     ln_we = 1'b1; ln_wa = rp; ln_wd = NIL;
                     lp_we = 1'b1; lp_wa = rp; lp_wd = NIL;
                     sub_in = '0;
                  end
               endcase
            end
         endcase

         if (sub_in == '0) begin
            case (state_ff)
               S_SPLRM: state_in = S_SPLPR;
               S_SPLPR: state_in = S_SPLPL;
               S_SPLPL: begin
                  cur_in = (cur_ff << 1) + NB'(1);
                  up_in = up_ff + BB'(1);
                  state_in = (up_ff + BB'(1) == tgt_ff) ? S_AFIND : S_SPL;
               end
               S_AGET: begin
                  rpage_in = rp;
                  mk_we = 1'b1; mk_wa = node_of(rp, tgt_ff); mk_wd = 1'b1;
                  state_in = S_RESP;
               end
               S_FPUT: begin
                  mk_we = 1'b1; mk_wa = cur_ff; mk_wd = 1'b0;
                  state_in = (up_ff == '0) ? S_RESP : S_MRD;
               end
               S_RM: begin
                  rmcnt_in = rmcnt_ff + 2'd1;
                  if (rmcnt_ff == 2'd1) begin
                     state_in = S_RMX;
                  end
               end
               S_RMW: state_in = (up_ff == '0) ? S_RESP : S_MRD;
               default: state_in = state_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         sub_ff <= '0;
         done_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= (i == 0) ? LB'(0) : NIL;
            tail_ff[i] <= (i == 0) ? LB'(0) : NIL;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         sub_ff <= sub_in;
         done_ff <= done_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
      tgt_ff <= tgt_in;
      up_ff <= up_in;
      cur_ff <= cur_in;
      off_ff <= off_in;
      ok_ff <= ok_in;
      rpage_ff <= rpage_in;
      rord_ff <= rord_in;
      rmcnt_ff <= rmcnt_in;
      pr_ff <= pr_in;
      nx_ff <= nx_in;
      mbit_ff <= mbit_in;
      rmpg_ff <= rmpg_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign rsp_ok = ok_ff;
   assign rsp_block_offset = 10'(rpage_ff);
   assign rsp_block_order = rord_ff;
endmodule

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
